[rtl/qbf_pkg.sv]
// ----------------------------------------------------------------------------
// qbf_pkg
// Types and constants shared by the quadratic Bezier flattener.
// ----------------------------------------------------------------------------
package qbf_pkg;

    localparam int MAX_LEVEL   = 6;
    localparam int FRAC_BITS   = 12;
    localparam int COORD_W     = 28;
    localparam int IN_W        = 16;
    localparam int TOL_W       = 20;
    localparam int LEVEL_W     = 3;
    localparam int STACK_DEPTH = MAX_LEVEL + 1;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIFF_W      = COORD_W + 1;
    localparam int HALF_W      = 2 * DIFF_W - 1;
    localparam int SQ_W        = 2 * HALF_W;
    localparam int MUL_W       = DIFF_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int TOL2_W      = 2 * TOL_W;
    localparam int ACC_W       = 120;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4096);

    typedef struct packed {
        logic signed [IN_W-1:0] start_x;
        logic signed [IN_W-1:0] start_y;
        logic signed [IN_W-1:0] control_x;
        logic signed [IN_W-1:0] control_y;
        logic signed [IN_W-1:0] finish_x;
        logic signed [IN_W-1:0] finish_y;
    } curve_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] edge_from_x;
        logic signed [COORD_W-1:0] edge_from_y;
        logic signed [COORD_W-1:0] edge_to_x;
        logic signed [COORD_W-1:0] edge_to_y;
        logic                      last_edge;
        logic                      depth_capped;
        logic                      zero_chord;
    } seg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic [LEVEL_W-1:0]        level;
    } piece_t;

endpackage

[rtl/quadratic_bezier_flattener.sv]
// ----------------------------------------------------------------------------
// quadratic_bezier_flattener
// Flattens one quadratic Bezier into line edges by depth-first midpoint
// subdivision on a piece stack held in a synchronous memory.
// Each piece is read from the stack and passes through the shared 30x30
// multiplier sequence (ST_C0 to ST_R3) before the flatness decision; a
// zero-length chord skips it and goes straight to emit. A curve holds up to
// 127 pieces, and curves are taken one at a time.
// Reset clears the control state and sets the tolerance to 4096.
// ----------------------------------------------------------------------------
module quadratic_bezier_flattener (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       curve_valid,
    output logic                       curve_stall,
    input  qbf_pkg::curve_t            curve,
    output logic                       seg_valid,
    input  logic                       seg_stall,
    output qbf_pkg::seg_t              seg,
    input  logic                       tol_we,
    input  logic [qbf_pkg::TOL_W-1:0]  tol_data
);

    typedef enum logic [16:0] {
        ST_IDLE  = 17'b00000000000000001,
        ST_READ  = 17'b00000000000000010,
        ST_DIFF  = 17'b00000000000000100,
        ST_C0    = 17'b00000000000001000,
        ST_C1    = 17'b00000000000010000,
        ST_K0    = 17'b00000000000100000,
        ST_K1    = 17'b00000000001000000,
        ST_Q0    = 17'b00000000010000000,
        ST_Q1    = 17'b00000000100000000,
        ST_Q2    = 17'b00000001000000000,
        ST_R0    = 17'b00000010000000000,
        ST_R1    = 17'b00000100000000000,
        ST_R2    = 17'b00001000000000000,
        ST_R3    = 17'b00010000000000000,
        ST_DEC   = 17'b00100000000000000,
        ST_PUSH2 = 17'b01000000000000000,
        ST_EMIT  = 17'b10000000000000000
    } state_t;

    localparam int CW = qbf_pkg::COORD_W;
    localparam int DW = qbf_pkg::DIFF_W;
    localparam int HW = qbf_pkg::HALF_W;
    localparam int MW = qbf_pkg::MUL_W;
    localparam int PW = qbf_pkg::PROD_W;
    localparam int AW = qbf_pkg::ACC_W;

    state_t                              state_reg, state_next;
    logic [qbf_pkg::TOL_W-1:0]           tol_reg;
    logic [qbf_pkg::TOP_W-1:0]           top_reg, top_next;
    qbf_pkg::piece_t                     stack_mem [qbf_pkg::STACK_DEPTH];
    qbf_pkg::piece_t                     rd_reg;
    qbf_pkg::piece_t                     wdata;
    logic                                mem_we;
    logic [qbf_pkg::STACK_AW-1:0]        waddr;
    logic signed [DW-1:0]                dx_reg, dy_reg, ex_reg, ey_reg;
    logic [qbf_pkg::TOL2_W-1:0]          tol2_reg;
    logic [HW-1:0]                       chord_reg;
    logic [HW-1:0]                       ak_reg;
    logic signed [AW-1:0]                acc_reg, acc_next;
    logic [qbf_pkg::SQ_W-1:0]            kk_reg;
    logic                                capped_reg, zero_reg;
    logic                                seg_valid_reg;
    qbf_pkg::seg_t                       seg_reg;
    logic signed [MW-1:0]                mul_a, mul_b;
    logic signed [PW-1:0]                prod;
    logic signed [AW-1:0]                prod_x;
    logic signed [DW-1:0]                dx_w, dy_w;
    logic signed [AW-1:0]                kdiff;
    logic signed [CW-1:0]                m0x, m0y, m2x, m2y, m1x, m1y;
    logic                                flat;
    logic                                out_free;
    qbf_pkg::piece_t                     first_piece;

    function automatic logic signed [MW-1:0] sx(input logic signed [DW-1:0] v);
        return {{(MW-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic signed [MW-1:0] zx(input logic [MW-2:0] v);
        return {1'b0, v};
    endfunction

    function automatic logic signed [CW-1:0] halfway(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[CW:1];
    endfunction

    function automatic logic signed [CW-1:0] scale(input logic signed [qbf_pkg::IN_W-1:0] v);
        logic signed [CW+qbf_pkg::FRAC_BITS-1:0] w;
        w = {{(CW+qbf_pkg::FRAC_BITS-qbf_pkg::IN_W){v[qbf_pkg::IN_W-1]}}, v}
            <<< qbf_pkg::FRAC_BITS;
        return w[CW-1:0];
    endfunction

    assign curve_stall = (state_reg != ST_IDLE);
    assign seg_valid   = seg_valid_reg;
    assign seg         = seg_reg;
    assign out_free    = !seg_valid_reg || !seg_stall;

    assign dx_w = {rd_reg.tx[CW-1], rd_reg.tx} - {rd_reg.fx[CW-1], rd_reg.fx};
    assign dy_w = {rd_reg.ty[CW-1], rd_reg.ty} - {rd_reg.fy[CW-1], rd_reg.fy};

    assign m0x = halfway(rd_reg.fx, rd_reg.cx);
    assign m0y = halfway(rd_reg.fy, rd_reg.cy);
    assign m2x = halfway(rd_reg.cx, rd_reg.tx);
    assign m2y = halfway(rd_reg.cy, rd_reg.ty);
    assign m1x = halfway(m0x, m2x);
    assign m1y = halfway(m0y, m2y);

    assign flat = ({{(AW-qbf_pkg::SQ_W){1'b0}}, kk_reg} <= acc_reg);

    always_comb
    begin
        first_piece.fx    = scale(curve.start_x);
        first_piece.fy    = scale(curve.start_y);
        first_piece.cx    = scale(curve.control_x);
        first_piece.cy    = scale(curve.control_y);
        first_piece.tx    = scale(curve.finish_x);
        first_piece.ty    = scale(curve.finish_y);
        first_piece.level = '0;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DIFF:
            begin
                mul_a = zx({{(MW-1-qbf_pkg::TOL_W){1'b0}}, tol_reg});
                mul_b = zx({{(MW-1-qbf_pkg::TOL_W){1'b0}}, tol_reg});
            end
            ST_C0:
            begin
                mul_a = sx(dx_reg);
                mul_b = sx(dx_reg);
            end
            ST_C1:
            begin
                mul_a = sx(dy_reg);
                mul_b = sx(dy_reg);
            end
            ST_K0:
            begin
                mul_a = sx(dy_reg);
                mul_b = sx(ex_reg);
            end
            ST_K1:
            begin
                mul_a = sx(dx_reg);
                mul_b = sx(ey_reg);
            end
            ST_Q0:
            begin
                mul_a = zx(ak_reg[HW-1:DW-1]);
                mul_b = zx(ak_reg[HW-1:DW-1]);
            end
            ST_Q1:
            begin
                mul_a = zx(ak_reg[HW-1:DW-1]);
                mul_b = zx({1'b0, ak_reg[DW-2:0]});
            end
            ST_Q2:
            begin
                mul_a = zx({1'b0, ak_reg[DW-2:0]});
                mul_b = zx({1'b0, ak_reg[DW-2:0]});
            end
            ST_R0:
            begin
                mul_a = zx({1'b0, tol2_reg[DW-2:0]});
                mul_b = zx({1'b0, chord_reg[DW-2:0]});
            end
            ST_R1:
            begin
                mul_a = zx({1'b0, tol2_reg[DW-2:0]});
                mul_b = zx(chord_reg[HW-1:DW-1]);
            end
            ST_R2:
            begin
                mul_a = zx({{(MW-1-(qbf_pkg::TOL2_W-DW+1)){1'b0}},
                            tol2_reg[qbf_pkg::TOL2_W-1:DW-1]});
                mul_b = zx({1'b0, chord_reg[DW-2:0]});
            end
            ST_R3:
            begin
                mul_a = zx({{(MW-1-(qbf_pkg::TOL2_W-DW+1)){1'b0}},
                            tol2_reg[qbf_pkg::TOL2_W-1:DW-1]});
                mul_b = zx(chord_reg[HW-1:DW-1]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_x = {{(AW-PW){prod[PW-1]}}, prod};
    assign kdiff  = acc_reg - prod_x;

    always_comb
    begin
        acc_next = acc_reg;
        case (state_reg)
            ST_C0, ST_K0, ST_R0: acc_next = prod_x;
            ST_C1:               acc_next = acc_reg + prod_x;
            ST_Q0:               acc_next = prod_x <<< (2 * (DW - 1));
            ST_Q1:               acc_next = acc_reg + (prod_x <<< DW);
            ST_R1, ST_R2:        acc_next = acc_reg + (prod_x <<< (DW - 1));
            ST_R3:               acc_next = acc_reg + (prod_x <<< (2 * (DW - 1)));
            default:             acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        top_next   = top_reg;
        mem_we     = 1'b0;
        waddr      = top_reg[qbf_pkg::STACK_AW-1:0];
        wdata      = first_piece;
        case (state_reg)
            ST_IDLE:
            begin
                if (curve_valid)
                begin
                    mem_we     = 1'b1;
                    waddr      = '0;
                    top_next   = qbf_pkg::TOP_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                top_next   = top_reg - qbf_pkg::TOP_W'(1);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                if (dx_w == '0 && dy_w == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_C0;
                end
            end
            ST_C0:  state_next = ST_C1;
            ST_C1:  state_next = ST_K0;
            ST_K0:  state_next = ST_K1;
            ST_K1:  state_next = ST_Q0;
            ST_Q0:  state_next = ST_Q1;
            ST_Q1:  state_next = ST_Q2;
            ST_Q2:  state_next = ST_R0;
            ST_R0:  state_next = ST_R1;
            ST_R1:  state_next = ST_R2;
            ST_R2:  state_next = ST_R3;
            ST_R3:  state_next = ST_DEC;
            ST_DEC:
            begin
                if (flat || rd_reg.level >= qbf_pkg::LEVEL_W'(qbf_pkg::MAX_LEVEL))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    wdata.fx    = rd_reg.fx;
                    wdata.fy    = rd_reg.fy;
                    wdata.cx    = m0x;
                    wdata.cy    = m0y;
                    wdata.tx    = m1x;
                    wdata.ty    = m1y;
                    wdata.level = rd_reg.level + qbf_pkg::LEVEL_W'(1);
                    if (top_reg < qbf_pkg::TOP_W'(qbf_pkg::STACK_DEPTH))
                    begin
                        mem_we   = 1'b1;
                        top_next = top_reg + qbf_pkg::TOP_W'(1);
                    end
                    state_next = ST_PUSH2;
                end
            end
            ST_PUSH2:
            begin
                wdata.fx    = m1x;
                wdata.fy    = m1y;
                wdata.cx    = m2x;
                wdata.cy    = m2y;
                wdata.tx    = rd_reg.tx;
                wdata.ty    = rd_reg.ty;
                wdata.level = rd_reg.level + qbf_pkg::LEVEL_W'(1);
                if (top_reg < qbf_pkg::TOP_W'(qbf_pkg::STACK_DEPTH))
                begin
                    mem_we   = 1'b1;
                    top_next = top_reg + qbf_pkg::TOP_W'(1);
                end
                state_next = ST_READ;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (top_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[waddr] <= wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_reg <= stack_mem[top_next[qbf_pkg::STACK_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            tol_reg       <= qbf_pkg::TOL_RESET;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            if (tol_we)
            begin
                tol_reg <= tol_data;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                seg_valid_reg <= 1'b1;
            end
            else if (!seg_stall)
            begin
                seg_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        case (state_reg)
            ST_DIFF:
            begin
                dx_reg     <= dx_w;
                dy_reg     <= dy_w;
                ex_reg     <= {rd_reg.cx[CW-1], rd_reg.cx} - {rd_reg.fx[CW-1], rd_reg.fx};
                ey_reg     <= {rd_reg.cy[CW-1], rd_reg.cy} - {rd_reg.fy[CW-1], rd_reg.fy};
                tol2_reg   <= prod[qbf_pkg::TOL2_W-1:0];
                capped_reg <= 1'b0;
                zero_reg   <= (dx_w == '0 && dy_w == '0);
            end
            ST_C1:
            begin
                chord_reg <= acc_next[HW-1:0];
            end
            ST_K1:
            begin
                ak_reg <= kdiff[AW-1] ? HW'(-kdiff) : kdiff[HW-1:0];
            end
            ST_Q2:
            begin
                kk_reg <= acc_reg[qbf_pkg::SQ_W-1:0] + prod_x[qbf_pkg::SQ_W-1:0];
            end
            ST_DEC:
            begin
                capped_reg <= !flat;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    seg_reg.edge_from_x  <= rd_reg.fx;
                    seg_reg.edge_from_y  <= rd_reg.fy;
                    seg_reg.edge_to_x    <= rd_reg.tx;
                    seg_reg.edge_to_y    <= rd_reg.ty;
                    seg_reg.last_edge    <= (top_reg == '0);
                    seg_reg.depth_capped <= capped_reg;
                    seg_reg.zero_chord   <= zero_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the quadratic Bezier flattener. Curves are
// driven in random bursts while the edge stream is stalled on a changing
// pattern. A scoreboard class predicts the edges of each accepted curve by
// midpoint subdivision and checks every edge in order. The tolerance
// register is swept over several values, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int MAX_EDGES      = 64;
    localparam int IN_W           = qbf_pkg::IN_W;
    localparam int COORD_W        = qbf_pkg::COORD_W;
    localparam int FRAC_BITS      = qbf_pkg::FRAC_BITS;
    localparam int TOL_W          = qbf_pkg::TOL_W;
    localparam int STACK_DEPTH    = qbf_pkg::STACK_DEPTH;
    localparam int MAX_LEVEL      = qbf_pkg::MAX_LEVEL;

    class edge_scoreboard;
        qbf_pkg::seg_t    edges_due[$];
        logic [TOL_W-1:0] tolerance;
        int               errors;
        int               curves_seen;
        int               edges_seen;
        int               capped_seen;
        int               zero_seen;
        longint           pfx[STACK_DEPTH];
        longint           pfy[STACK_DEPTH];
        longint           pcx[STACK_DEPTH];
        longint           pcy[STACK_DEPTH];
        longint           ptx[STACK_DEPTH];
        longint           pty[STACK_DEPTH];
        int               plevel[STACK_DEPTH];
        int               depth;

        function new();
            tolerance = qbf_pkg::TOL_RESET;
            errors = 0;
            curves_seen = 0;
            edges_seen = 0;
            capped_seen = 0;
            zero_seen = 0;
            depth = 0;
        endfunction

        function longint scale(logic signed [IN_W-1:0] v);
            logic signed [COORD_W-1:0] w;
            w = COORD_W'(longint'(v) <<< FRAC_BITS);
            return longint'(w);
        endfunction

        function longint halfway(longint a, longint b);
            return (a + b) >>> 1;
        endfunction

        function void push_piece(longint fx, longint fy, longint cx, longint cy,
                                 longint tx, longint ty, int lvl);
            if (depth < STACK_DEPTH)
            begin
                pfx[depth] = fx;
                pfy[depth] = fy;
                pcx[depth] = cx;
                pcy[depth] = cy;
                ptx[depth] = tx;
                pty[depth] = ty;
                plevel[depth] = lvl;
                depth++;
            end
        endfunction

        function qbf_pkg::seg_t make_edge(longint fx, longint fy, longint tx, longint ty,
                                          logic capped, logic zero);
            qbf_pkg::seg_t s;
            s.edge_from_x  = COORD_W'(fx);
            s.edge_from_y  = COORD_W'(fy);
            s.edge_to_x    = COORD_W'(tx);
            s.edge_to_y    = COORD_W'(ty);
            s.last_edge    = 1'b0;
            s.depth_capped = capped;
            s.zero_chord   = zero;
            return s;
        endfunction

        function void note_curve(qbf_pkg::curve_t c);
            qbf_pkg::seg_t fresh[$];
            longint        fx, fy, cx, cy, tx, ty, dx, dy, k;
            longint        m0x, m0y, m2x, m2y, m1x, m1y;
            int            lvl;
            logic [63:0]   chord2, ak, tol2;
            logic [127:0]  lhs, rhs;
            curves_seen++;
            tol2 = 64'(tolerance) * 64'(tolerance);
            depth = 0;
            push_piece(scale(c.start_x), scale(c.start_y), scale(c.control_x),
                       scale(c.control_y), scale(c.finish_x), scale(c.finish_y), 0);
            while (depth > 0 && fresh.size() < MAX_EDGES)
            begin
                depth--;
                fx = pfx[depth];
                fy = pfy[depth];
                cx = pcx[depth];
                cy = pcy[depth];
                tx = ptx[depth];
                ty = pty[depth];
                lvl = plevel[depth];
                dx = tx - fx;
                dy = ty - fy;
                chord2 = 64'(dx * dx) + 64'(dy * dy);
                if (chord2 == 64'd0)
                begin
                    fresh.push_back(make_edge(fx, fy, tx, ty, 1'b0, 1'b1));
                end
                else
                begin
                    k = dy * (cx - fx) - dx * (cy - fy);
                    ak = (k < 0) ? 64'(-k) : 64'(k);
                    lhs = {64'd0, ak} * {64'd0, ak};
                    rhs = {64'd0, tol2} * {64'd0, chord2};
                    if (lhs <= rhs)
                        fresh.push_back(make_edge(fx, fy, tx, ty, 1'b0, 1'b0));
                    else if (lvl >= MAX_LEVEL)
                        fresh.push_back(make_edge(fx, fy, tx, ty, 1'b1, 1'b0));
                    else
                    begin
                        m0x = halfway(fx, cx);
                        m0y = halfway(fy, cy);
                        m2x = halfway(cx, tx);
                        m2y = halfway(cy, ty);
                        m1x = halfway(m0x, m2x);
                        m1y = halfway(m0y, m2y);
                        push_piece(fx, fy, m0x, m0y, m1x, m1y, lvl + 1);
                        push_piece(m1x, m1y, m2x, m2y, tx, ty, lvl + 1);
                    end
                end
            end
            depth = 0;
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last_edge = 1'b1;
            foreach (fresh[i])
                edges_due.push_back(fresh[i]);
        endfunction

        function void check_edge(qbf_pkg::seg_t got);
            qbf_pkg::seg_t want;
            edges_seen++;
            if (got.depth_capped)
                capped_seen++;
            if (got.zero_chord)
                zero_seen++;
            if (edges_due.size() == 0)
            begin
                $display("%0t: unexpected edge %h", $time, got);
                errors++;
            end
            else
            begin
                want = edges_due.pop_front();
                if (got !== want)
                begin
                    $display("%0t: edge mismatch expected from (%0d,%0d) to (%0d,%0d) l%b c%b z%b",
                             $time, want.edge_from_x, want.edge_from_y, want.edge_to_x,
                             want.edge_to_y, want.last_edge, want.depth_capped,
                             want.zero_chord);
                    $display("%0t: edge mismatch actual   from (%0d,%0d) to (%0d,%0d) l%b c%b z%b",
                             $time, got.edge_from_x, got.edge_from_y, got.edge_to_x,
                             got.edge_to_y, got.last_edge, got.depth_capped, got.zero_chord);
                    errors++;
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             curve_valid;
    logic             curve_stall;
    qbf_pkg::curve_t  curve;
    logic             seg_valid;
    logic             seg_stall = 1'b0;
    qbf_pkg::seg_t    seg;
    logic             tol_we;
    logic [TOL_W-1:0] tol_data;

    edge_scoreboard   sb;
    int               curves_sent;
    int               idle_cycles = 0;
    int               hold_left = 0;
    bit               hold_done = 1'b0;
    int               stall_pct = 0;
    int               pattern_left = 0;

    quadratic_bezier_flattener uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .curve_valid (curve_valid),
        .curve_stall (curve_stall),
        .curve       (curve),
        .seg_valid   (seg_valid),
        .seg_stall   (seg_stall),
        .seg         (seg),
        .tol_we      (tol_we),
        .tol_data    (tol_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (curve_valid && !curve_stall)
                sb.note_curve(curve);
            if (seg_valid && !seg_stall)
                sb.check_edge(seg);
            if ((curve_valid && !curve_stall) || (seg_valid && !seg_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: watchdog expired at %0t", $time);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!hold_done && curves_sent >= 150)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            seg_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            seg_stall <= 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 20;
                    2: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
                pattern_left <= $urandom_range(50, 300);
            end
            else
                pattern_left <= pattern_left - 1;
            seg_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_curve(qbf_pkg::curve_t c);
        @(negedge clk);
        curve_valid <= 1'b1;
        curve <= c;
        do
            @(posedge clk);
        while (curve_stall);
        curves_sent++;
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            curve_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        curve_valid <= 1'b0;
        while (sb.edges_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] v);
        drain();
        @(negedge clk);
        tol_we <= 1'b1;
        tol_data <= v;
        sb.tolerance = v;
        @(negedge clk);
        tol_we <= 1'b0;
    endtask

    function automatic qbf_pkg::curve_t pack_curve(int sx, int sy, int cx, int cy,
                                                   int fx, int fy);
        qbf_pkg::curve_t c;
        c.start_x   = IN_W'(sx);
        c.start_y   = IN_W'(sy);
        c.control_x = IN_W'(cx);
        c.control_y = IN_W'(cy);
        c.finish_x  = IN_W'(fx);
        c.finish_y  = IN_W'(fy);
        return c;
    endfunction

    function automatic int near(int base, int spread);
        return base + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic qbf_pkg::curve_t random_curve();
        qbf_pkg::curve_t c;
        int              bx, by, fx, fy, pick;
        pick = $urandom_range(0, 99);
        bx = int'($urandom_range(0, 60000)) - 30000;
        by = int'($urandom_range(0, 60000)) - 30000;
        fx = near(bx, 64);
        fy = near(by, 64);
        if (pick < 50)
            c = pack_curve(bx, by, near(bx, 64), near(by, 64), fx, fy);
        else if (pick < 75)
            c = pack_curve(bx, by, near((bx + fx) / 2, 2), near((by + fy) / 2, 2), fx, fy);
        else if (pick < 88)
            c = pack_curve(bx, by, near(bx, 64), near(by, 64), bx, by);
        else
        begin
            c = qbf_pkg::curve_t'({$urandom, $urandom, $urandom});
            if (pick < 91)
            begin
                c.finish_x = c.start_x;
                c.finish_y = c.start_y;
            end
        end
        return c;
    endfunction

    task automatic random_phase(int count, bit pause_midway);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && left > 0)
            begin
                send_curve(random_curve());
                burst--;
                left--;
                if (pause_midway && left == count / 2)
                    drain();
            end
            idle_sender($urandom_range(0, 5));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        curve_valid = 1'b0;
        curve = '0;
        tol_we = 1'b0;
        tol_data = '0;
        curves_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_curve(pack_curve(32767, 32767, 32767, 32767, 32767, 32767));
        send_curve(pack_curve(-32768, -32768, -32768, -32768, -32768, -32768));
        send_curve(pack_curve(-32768, 32767, 32767, -32768, -32768, 32767));
        send_curve(pack_curve(-32768, -32768, 32767, -32768, 32767, 32767));
        send_curve(pack_curve(32767, 32767, -32768, 32767, -32768, -32768));
        send_curve(pack_curve(0, 0, 5, 5, 10, 10));
        send_curve(pack_curve(0, 0, 1, 0, 2, 0));
        send_curve(pack_curve(0, 0, 1, 1, 2, 0));
        send_curve(pack_curve(-5, -7, 40, 90, 100, -3));
        send_curve(pack_curve(-1, -1, 0, 0, 1, 1));

        write_tolerance(20'd0);
        send_curve(pack_curve(0, 0, 3, 3, 6, 6));
        send_curve(pack_curve(0, 0, 1, 1, 2, 0));
        send_curve(pack_curve(-32768, -32768, 32767, -32768, 32767, 32767));
        send_curve(pack_curve(100, 100, 300, 300, 100, 100));

        write_tolerance(20'hFFFFF);
        send_curve(pack_curve(-32768, -32768, 32767, -32768, 32767, 32767));
        send_curve(pack_curve(-32768, 32767, 32767, 32767, 32767, -32768));
        send_curve(pack_curve(0, 0, -32768, 32767, 1, 0));

        random_phase(20, 1'b0);
        write_tolerance(20'd4096);
        random_phase(200, 1'b1);
        write_tolerance(20'd0);
        random_phase(20, 1'b0);
        write_tolerance(20'd1);
        random_phase(40, 1'b0);
        write_tolerance(20'hFFFFF);
        random_phase(40, 1'b0);
        write_tolerance(TOL_W'($urandom_range(2, 20000)));
        random_phase(60, 1'b0);
        write_tolerance(TOL_W'($urandom));
        random_phase(50, 1'b0);

        drain();
        $display("Run covered %0d curves and %0d edges, %0d depth capped, %0d zero chord.",
                 sb.curves_seen, sb.edges_seen, sb.capped_seen, sb.zero_seen);
        $display("Tolerance was swept through zero, one, full scale and random values.");
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/qbf_pkg.sv
rtl/quadratic_bezier_flattener.sv
tb/tb_top.sv
